/* design/mavg_pkg.sv */
// ----------------------------------------------------------------------------
// Moving average filter package
// Shared widths, defaults and the control bundle for the window cells.
// ----------------------------------------------------------------------------
`default_nettype none

package mavg_pkg;

    // Default number of cells in the window chain.
    localparam int MAX_WINDOW_DEF = 32;

    // Sample and result width, fixed by the interface.
    localparam int SAMPLE_W = 16;

    // Width of the window length register port.
    localparam int CFG_W = 6;

    // Window length after reset, before clamping to the chain length.
    localparam int WINDOW_LENGTH_RESET = 8;

    // Control that every cell of the window chain receives.
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctl_t;

endpackage

`default_nettype wire

/* design/mavg_cell.sv */
// ----------------------------------------------------------------------------
// Moving average window cell
// Holds one sample of the window and takes its neighbor's sample on a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module mavg_cell (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire mavg_pkg::cell_ctl_t                   ctl,
    input  wire logic signed [mavg_pkg::SAMPLE_W-1:0]  d,
    output logic signed [mavg_pkg::SAMPLE_W-1:0]       q
);
    import mavg_pkg::*;

    logic signed [SAMPLE_W-1:0] data_reg;
    logic signed [SAMPLE_W-1:0] data_next;

    // A clear empties the cell; a shift takes the neighbor's sample.
    always_comb
    begin
        data_next = data_reg;
        if (ctl.clear)
        begin
            data_next = '0;
        end
        else if (ctl.shift)
        begin
            data_next = d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            data_reg <= '0;
        end
        else
        begin
            data_reg <= data_next;
        end
    end

    assign q = data_reg;

endmodule

`default_nettype wire

/* design/mavg_div.sv */
// ----------------------------------------------------------------------------
// Moving average divider
// Signed sum divided by the window length, one quotient bit per cycle,
// truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module mavg_div #(
    parameter int SUM_W = 22,
    parameter int LEN_W = 6
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  start,
    input  wire logic signed [SUM_W-1:0]               dividend,
    input  wire logic [LEN_W-1:0]                      divisor,
    output logic                                       done,
    output logic signed [mavg_pkg::SAMPLE_W-1:0]       quotient
);
    import mavg_pkg::*;

    // The magnitude of the sum always fits one bit less than the sum.
    localparam int NUM_W = SUM_W - 1;
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             neg_reg, neg_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [LEN_W-1:0] rem_reg, rem_next;
    logic [LEN_W-1:0] den_reg, den_next;

    logic [SUM_W-1:0] mag_full;
    logic [LEN_W:0]   rem_shift;
    logic [LEN_W:0]   rem_diff;
    logic             fits;
    logic [NUM_W-1:0] quo_signed;

    // Magnitude of the incoming sum.
    assign mag_full = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);

    // One restoring step: bring down the next dividend bit and try a subtract.
    assign rem_shift = {rem_reg, quo_reg[NUM_W-1]};
    assign rem_diff  = rem_shift - {1'b0, den_reg};
    assign fits      = (rem_shift >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            neg_next  = dividend[SUM_W-1];
            cnt_next  = '0;
            quo_next  = mag_full[NUM_W-1:0];
            rem_next  = '0;
            den_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[NUM_W-2:0], fits};
            rem_next = fits ? rem_diff[LEN_W-1:0] : rem_shift[LEN_W-1:0];
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    // Restore the sign; the quotient magnitude is held until the next start.
    assign quo_signed = neg_reg ? NUM_W'(-quo_reg) : quo_reg;
    assign quotient   = quo_signed[SAMPLE_W-1:0];
    assign done       = done_reg;

endmodule

`default_nettype wire

/* design/moving_average_filter.sv */
// ----------------------------------------------------------------------------
// Moving average filter
// Each accepted request runs through the load, divide and deliver states, with
// the sum divided by the bit-serial divider; no new request is taken until the
// result has moved into the output register.
// Reset and every window length write clear the window chain and the sum.
// ----------------------------------------------------------------------------
`default_nettype none

module moving_average_filter #(
    parameter int MAX_WINDOW = mavg_pkg::MAX_WINDOW_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [mavg_pkg::CFG_W-1:0]            window_length,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic signed [mavg_pkg::SAMPLE_W-1:0]  sample,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic signed [mavg_pkg::SAMPLE_W-1:0]       average
);
    import mavg_pkg::*;

    localparam int LEN_W   = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W   = SAMPLE_W + LEN_W;
    localparam int IDX_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CMP_W   = (LEN_W > CFG_W) ? LEN_W : CFG_W;
    localparam int RST_LEN = (WINDOW_LENGTH_RESET > MAX_WINDOW) ? MAX_WINDOW
                                                               : WINDOW_LENGTH_RESET;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_LOAD    = 4'b0010,
        ST_DIVIDE  = 4'b0100,
        ST_DELIVER = 4'b1000
    } state_t;

    state_t                     state_reg, state_next;
    logic [LEN_W-1:0]           len_reg, len_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] average_reg, average_next;

    logic                       in_accept;
    logic                       out_take;
    logic [CMP_W-1:0]           cfg_ext;
    logic [LEN_W-1:0]           cfg_len;
    logic [LEN_W-1:0]           tap_full;
    logic [IDX_W-1:0]           tap_idx;
    logic signed [SAMPLE_W-1:0] leave_sample;
    cell_ctl_t                  cell_ctl;
    logic signed [SAMPLE_W-1:0] cell_q [MAX_WINDOW];
    logic                       div_done;
    logic signed [SAMPLE_W-1:0] div_quotient;

    assign in_accept = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign in_stall  = (state_reg != ST_IDLE);

    // Clamp a written window length to the range of the chain.
    assign cfg_ext = CMP_W'(window_length);
    always_comb
    begin
        if (cfg_ext == '0)
        begin
            cfg_len = LEN_W'(1);
        end
        else if (cfg_ext > CMP_W'(MAX_WINDOW))
        begin
            cfg_len = LEN_W'(MAX_WINDOW);
        end
        else
        begin
            cfg_len = cfg_ext[LEN_W-1:0];
        end
    end

    // The cells shift on every accepted request and clear on a length write.
    assign cell_ctl.shift = in_accept;
    assign cell_ctl.clear = cfg_we;

    // Window chain: cell 0 takes the new sample, each later cell its neighbor.
    for (genvar k = 0; k < MAX_WINDOW; k++)
    begin : g_cell
        if (k == 0)
        begin : g_head
            mavg_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctl   (cell_ctl),
                .d     (sample),
                .q     (cell_q[k])
            );
        end
        else
        begin : g_body
            mavg_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctl   (cell_ctl),
                .d     (cell_q[k-1]),
                .q     (cell_q[k])
            );
        end
    end

    // The sample leaving the window sits in the last cell of the window.
    assign tap_full     = len_reg - LEN_W'(1);
    assign tap_idx      = tap_full[IDX_W-1:0];
    assign leave_sample = cell_q[tap_idx];

    // Running sum and window length.
    always_comb
    begin
        len_next = len_reg;
        sum_next = sum_reg;
        if (cfg_we)
        begin
            len_next = cfg_len;
            sum_next = '0;
        end
        else if (in_accept)
        begin
            sum_next = sum_reg - SUM_W'(leave_sample) + SUM_W'(sample);
        end
    end

    mavg_div #(
        .SUM_W (SUM_W),
        .LEN_W (LEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_LOAD),
        .dividend (sum_reg),
        .divisor  (len_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // Sequencer and output register.
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        average_next   = average_reg;
        if (out_take)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = ST_DELIVER;
                end
            end
            ST_DELIVER:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    average_next   = div_quotient;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= LEN_W'(RST_LEN);
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        average_reg <= average_next;
    end

    assign out_valid = out_valid_reg;
    assign average   = average_reg;

    // The divider reports completion only while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIVIDE))
        else $error("divider finished outside the divide state");

    // The window length always selects a cell inside the chain.
    assert property (@(posedge clk) disable iff (!rst_n)
        (len_reg >= LEN_W'(1)) && (len_reg <= LEN_W'(MAX_WINDOW)))
        else $error("window length outside the chain");

    // A length write leaves an empty sum behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (sum_reg == '0))
        else $error("sum not cleared by a window length write");

endmodule

`default_nettype wire

/* test/average_checker.sv */
// ----------------------------------------------------------------------------
// Moving average filter checker
// Watches the configuration port and both request channels of the filter.
// It keeps its own copy of the sample window and the running sum, works out
// the average for every accepted request, and compares each accepted result
// with the oldest outstanding average.
// ----------------------------------------------------------------------------
module average_checker #(
    parameter int MAX_WINDOW = mavg_pkg::MAX_WINDOW_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [mavg_pkg::CFG_W-1:0]            window_length,
    input  logic                                  in_valid,
    input  logic                                  in_stall,
    input  logic signed [mavg_pkg::SAMPLE_W-1:0]  sample,
    input  logic                                  out_valid,
    input  logic                                  out_stall,
    input  logic signed [mavg_pkg::SAMPLE_W-1:0]  average,
    output int                                    mismatches,
    output int                                    outstanding,
    output int                                    samples_taken,
    output int                                    averages_checked
);
    import mavg_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // Shadow of the filter state.
    logic signed [SAMPLE_W-1:0] window_store [MAX_WINDOW];
    int                         window_sum;
    int                         oldest_pos;
    int                         active_length;

    // Averages still owed by the filter, oldest first.
    logic signed [SAMPLE_W-1:0] pending_averages [$];

    logic signed [SAMPLE_W-1:0] oldest_average;
    logic signed [SAMPLE_W-1:0] new_average;
    int                         error_count;
    int                         request_count;
    int                         result_count;

    // Out-of-range lengths are clamped: zero acts as one, anything above the
    // chain length acts as the full chain.
    function automatic int effective_length(input logic [CFG_W-1:0] raw);
        if (raw == '0)
            return 1;
        if (int'(raw) > MAX_WINDOW)
            return MAX_WINDOW;
        return int'(raw);
    endfunction

    task automatic clear_window();
        for (int i = 0; i < MAX_WINDOW; i++)
            window_store[i] = '0;
        window_sum = 0;
        oldest_pos = 0;
    endtask

    // Replace the oldest sample, update the sum and divide with truncation
    // toward zero.
    task automatic slide_window(input logic signed [SAMPLE_W-1:0] s,
                                output logic signed [SAMPLE_W-1:0] mean);
        int pos;
        int quotient;
        pos = oldest_pos;
        if (pos >= active_length)
            pos = 0;
        window_sum = window_sum - int'(window_store[pos]) + int'(s);
        window_store[pos] = s;
        pos++;
        if (pos >= active_length)
            pos = 0;
        oldest_pos = pos;
        quotient = window_sum / active_length;
        mean = quotient[SAMPLE_W-1:0];
    endtask

    task automatic report_error(input string what,
                                input logic signed [SAMPLE_W-1:0] wanted,
                                input logic signed [SAMPLE_W-1:0] got);
        error_count++;
        if (error_count <= REPORT_LIMIT)
            $display("%0t: %s: expected average %0d, got %0d",
                     $time, what, wanted, got);
    endtask

    // Compare results first so that the oldest entry is always the one used,
    // then apply a register write, then take a new request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_length = effective_length(CFG_W'(WINDOW_LENGTH_RESET));
            clear_window();
            pending_averages.delete();
            error_count = 0;
            request_count = 0;
            result_count = 0;
            mismatches <= 0;
            outstanding <= 0;
            samples_taken <= 0;
            averages_checked <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                result_count++;
                if (pending_averages.size() == 0)
                    report_error("result with no request outstanding", '0, average);
                else
                begin
                    oldest_average = pending_averages.pop_front();
                    if (average !== oldest_average)
                        report_error("average mismatch", oldest_average, average);
                end
            end
            if (cfg_we)
            begin
                active_length = effective_length(window_length);
                clear_window();
            end
            if (in_valid && !in_stall)
            begin
                request_count++;
                slide_window(sample, new_average);
                pending_averages.push_back(new_average);
            end
            mismatches <= error_count;
            outstanding <= pending_averages.size();
            samples_taken <= request_count;
            averages_checked <= result_count;
        end
    end

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// Moving average filter testbench
// Drives samples and window length writes into the filter with random gaps
// and output stalls, including one long output hold-off, and leaves all
// checking to the checker instance beside the filter.
// ----------------------------------------------------------------------------
module testbench;
    import mavg_pkg::*;

    localparam int LIMIT_CYCLES     = 1500000;
    localparam int SETTLE_CYCLES    = 30;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int PHASES           = 20;
    localparam int HOLD_PHASE       = 4;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_we;
    logic [CFG_W-1:0]            cfg_length;
    logic                        in_valid;
    logic                        in_stall;
    logic signed [SAMPLE_W-1:0]  sample;
    logic                        out_valid;
    logic                        out_stall;
    logic signed [SAMPLE_W-1:0]  average;

    int mismatches;
    int outstanding;
    int samples_taken;
    int averages_checked;
    int cycle_count;
    int length_writes;
    bit want_long_hold;
    bit long_hold_done;

    moving_average_filter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .window_length (cfg_length),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .sample        (sample),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .average       (average)
    );

    average_checker avg_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .window_length    (cfg_length),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .sample           (sample),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .average          (average),
        .mismatches       (mismatches),
        .outstanding      (outstanding),
        .samples_taken    (samples_taken),
        .averages_checked (averages_checked)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Watchdog on the whole run.
    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("moving_average_filter regression: fail");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one; none inside a burst.
    function automatic int pick_gap(input bit burst);
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 40)
            return 0;
        if (r < 85)
            return $urandom_range(1, 5);
        if (r < 97)
            return $urandom_range(6, 30);
        return $urandom_range(31, 80);
    endfunction

    // Samples mix full-range values, the extremes and values near zero.
    function automatic logic signed [SAMPLE_W-1:0] next_sample(input int extreme_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < extreme_pct)
        begin
            case ($urandom_range(0, 5))
                0:       return SAMPLE_MAX;
                1:       return SAMPLE_MIN;
                2:       return -16'sd1;
                3:       return 16'sd1;
                4:       return -16'sd32767;
                default: return '0;
            endcase
        end
        if (r < extreme_pct + 20)
            return SAMPLE_W'($urandom_range(0, 16) - 8);
        return SAMPLE_W'($urandom_range(0, 65535));
    endfunction

    // Window lengths for the first phases cover the clamped and extreme
    // settings; later phases pick any register value.
    function automatic logic [CFG_W-1:0] planned_length(input int phase);
        case (phase)
            0:       return CFG_W'(0);
            1:       return CFG_W'(1);
            2:       return CFG_W'(32);
            3:       return CFG_W'(33);
            4:       return CFG_W'(63);
            5:       return CFG_W'(2);
            6:       return CFG_W'(5);
            7:       return CFG_W'(16);
            8:       return CFG_W'(31);
            9:       return CFG_W'(12);
            default: return CFG_W'($urandom_range(0, 63));
        endcase
    endfunction

    // Offer one request after an optional gap and wait until it is taken.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] value, input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample <= value;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Wait until every average has come back and the divider has settled.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_length(input logic [CFG_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_length <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        length_writes++;
    endtask

    // Output side: runs of free flow, random stalls and short or long
    // holds, plus one long hold-off on request from the stimulus.
    initial
    begin
        int mode;
        int run;
        out_stall = 1'b0;
        long_hold_done = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (want_long_hold && !long_hold_done)
            begin
                out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_hold_done = 1'b1;
            end
            else
            begin
                mode = $urandom_range(0, 9);
                if (mode <= 3)
                    run = $urandom_range(1, 40);
                else if (mode <= 6)
                    run = $urandom_range(5, 40);
                else if (mode <= 8)
                    run = $urandom_range(1, 5);
                else
                    run = $urandom_range(20, 60);
                for (int i = 0; i < run; i++)
                begin
                    if (mode <= 3)
                        out_stall <= 1'b0;
                    else if (mode <= 6)
                        out_stall <= ($urandom_range(0, 99) < 30);
                    else
                        out_stall <= 1'b1;
                    @(posedge clk);
                end
            end
        end
    end

    // Stimulus and verdict.
    initial
    begin
        int item_total;
        int extreme_pct;
        bit burst;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_length = '0;
        in_valid = 1'b0;
        sample = '0;
        want_long_hold = 1'b0;
        length_writes = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed samples at the reset length: a full window of the largest
        // value, a full window of the most negative one, then small and alternating-bit
        // values whose negative sums must truncate toward zero.
        for (int i = 0; i < 8; i++)
            send_sample(SAMPLE_MAX, pick_gap(1'b0));
        for (int i = 0; i < 8; i++)
            send_sample(SAMPLE_MIN, pick_gap(1'b0));
        send_sample(-16'sd1, pick_gap(1'b0));
        send_sample(16'sd1, pick_gap(1'b0));
        send_sample(16'sh5555, pick_gap(1'b0));
        send_sample(16'shAAAA, pick_gap(1'b0));
        send_sample(-16'sd3, pick_gap(1'b0));
        send_sample(-16'sd1, pick_gap(1'b0));
        send_sample(16'sd0, pick_gap(1'b0));
        drain_results();

        // Random phases, each after a fresh window length write.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            write_length(planned_length(phase));
            item_total = $urandom_range(60, 100);
            extreme_pct = (phase % 3 == 0) ? 60 : 10;
            burst = (phase % 4 == 1) || (phase == HOLD_PHASE);
            if (phase == HOLD_PHASE)
                want_long_hold = 1'b1;
            for (int i = 0; i < item_total; i++)
                send_sample(next_sample(extreme_pct), pick_gap(burst));
            drain_results();
        end

        $display("Covered %0d samples and %0d averages over %0d window length writes,",
                 samples_taken, averages_checked, length_writes);
        $display("including lengths 0, 1, 32, 33 and 63 and one long output hold-off.");
        if (mismatches == 0 && outstanding == 0)
            $display("moving_average_filter regression: pass");
        else
            $display("moving_average_filter regression: fail");
        $finish;
    end

endmodule
